// ----- src/gcs_pkg.sv -----
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared types, request codes and the control store of the GLCD command
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gcs_pkg;

	localparam int PC_W = 5;

	typedef logic [PC_W-1:0] pc_t;

	// request codes on func
	localparam logic [2:0] FUNC_INIT  = 3'd0;
	localparam logic [2:0] FUNC_CLEAR = 3'd1;
	localparam logic [2:0] FUNC_PLOT  = 3'd2;
	localparam logic [2:0] FUNC_CHAR  = 3'd3;
	localparam logic [2:0] FUNC_LOAD  = 3'd4;

	// controller command bytes
	localparam logic [7:0] CMD_DISP_ON = 8'h3F;
	localparam logic [7:0] CMD_SET_Y   = 8'h40;
	localparam logic [7:0] CMD_PAGE    = 8'hB8;
	localparam logic [7:0] CMD_START   = 8'hC0;

	localparam logic [7:0] CHAR_FIRST  = 8'd32;
	localparam logic [7:0] LINE_FIRST  = 8'd1;
	localparam logic [7:0] LINE_LAST   = 8'd8;

	// program entry points
	localparam pc_t PC_INIT  = 5'd0;
	localparam pc_t PC_CLEAR = 5'd8;
	localparam pc_t PC_PLOT  = 5'd11;
	localparam pc_t PC_LINE  = 5'd14;
	localparam pc_t PC_CHAR  = 5'd18;
	localparam pc_t PC_GLYPH = 5'd19;

	typedef enum logic [1:0] {
		H_LEFT,
		H_RIGHT,
		H_REQ
	} half_sel_t;

	typedef enum logic [2:0] {
		B_CONST,
		B_PAGE,
		B_CNT_PAGE,
		B_YADDR,
		B_MASK,
		B_FONT
	} byte_sel_t;

	typedef struct packed {
		logic      emit;
		half_sel_t hsel;
		logic      rs;
		byte_sel_t bsel;
		logic [7:0] cbyte;
		logic      loop;   // repeat to tgt while counter != 7
		pc_t       tgt;
		logic      done;   // program ends after this step
	} uc_word_t;

	function automatic uc_word_t uc_make(logic emit, half_sel_t hsel, logic rs,
			byte_sel_t bsel, logic [7:0] cbyte, logic loop, pc_t tgt, logic done);
		uc_word_t w;
		w.emit  = emit;
		w.hsel  = hsel;
		w.rs    = rs;
		w.bsel  = bsel;
		w.cbyte = cbyte;
		w.loop  = loop;
		w.tgt   = tgt;
		w.done  = done;
		return w;
	endfunction

	function automatic uc_word_t uc_rom(pc_t pc);
		uc_word_t w;
		case (pc)
			// init
			5'd0:  w = uc_make(1'b1, H_LEFT,  1'b0, B_CONST, CMD_DISP_ON, 1'b0, 5'd0, 1'b0);
			5'd1:  w = uc_make(1'b1, H_RIGHT, 1'b0, B_CONST, CMD_DISP_ON, 1'b0, 5'd0, 1'b0);
			5'd2:  w = uc_make(1'b1, H_LEFT,  1'b0, B_CONST, CMD_SET_Y,   1'b0, 5'd0, 1'b0);
			5'd3:  w = uc_make(1'b1, H_RIGHT, 1'b0, B_CONST, CMD_SET_Y,   1'b0, 5'd0, 1'b0);
			5'd4:  w = uc_make(1'b1, H_LEFT,  1'b0, B_CONST, CMD_PAGE,    1'b0, 5'd0, 1'b0);
			5'd5:  w = uc_make(1'b1, H_RIGHT, 1'b0, B_CONST, CMD_PAGE,    1'b0, 5'd0, 1'b0);
			5'd6:  w = uc_make(1'b1, H_LEFT,  1'b0, B_CONST, CMD_START,   1'b0, 5'd0, 1'b0);
			5'd7:  w = uc_make(1'b1, H_RIGHT, 1'b0, B_CONST, CMD_START,   1'b0, 5'd0, 1'b1);
			// clear column, eight pages
			5'd8:  w = uc_make(1'b1, H_REQ,   1'b0, B_CNT_PAGE, 8'h00, 1'b0, 5'd0, 1'b0);
			5'd9:  w = uc_make(1'b1, H_REQ,   1'b0, B_YADDR,    8'h00, 1'b0, 5'd0, 1'b0);
			5'd10: w = uc_make(1'b1, H_REQ,   1'b1, B_CONST,    8'h00, 1'b1, PC_CLEAR, 1'b1);
			// plot
			5'd11: w = uc_make(1'b1, H_REQ,   1'b0, B_PAGE,  8'h00, 1'b0, 5'd0, 1'b0);
			5'd12: w = uc_make(1'b1, H_REQ,   1'b0, B_YADDR, 8'h00, 1'b0, 5'd0, 1'b0);
			5'd13: w = uc_make(1'b1, H_REQ,   1'b1, B_MASK,  8'h00, 1'b0, 5'd0, 1'b1);
			// line select
			5'd14: w = uc_make(1'b1, H_LEFT,  1'b0, B_PAGE,  8'h00,     1'b0, 5'd0, 1'b0);
			5'd15: w = uc_make(1'b1, H_RIGHT, 1'b0, B_PAGE,  8'h00,     1'b0, 5'd0, 1'b0);
			5'd16: w = uc_make(1'b1, H_LEFT,  1'b0, B_CONST, CMD_SET_Y, 1'b0, 5'd0, 1'b0);
			5'd17: w = uc_make(1'b1, H_RIGHT, 1'b0, B_CONST, CMD_SET_Y, 1'b0, 5'd0, 1'b1);
			// character: prime the font read, then eight data bytes
			5'd18: w = uc_make(1'b0, H_REQ,   1'b0, B_CONST, 8'h00, 1'b0, 5'd0, 1'b0);
			5'd19: w = uc_make(1'b1, H_REQ,   1'b1, B_FONT,  8'h00, 1'b1, PC_GLYPH, 1'b1);
			default: w = uc_make(1'b0, H_LEFT, 1'b0, B_CONST, 8'h00, 1'b0, 5'd0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- src/glcd_command_sequencer_unit.sv -----
// First write: registered from the first step of the request's program; a
//   character's first step only primes the font store read.
// Throughput: one write per cycle unless the output stalls; the input stays
//   closed while a program runs (8 init, 24 clear column, 3 plot, 4 line
//   select, 9 character steps); loads and ignored requests leave it open.
// Reset: sequencer idle, output empty, text column 0; font store not cleared.
// ----------------------------------------------------------------------------
// glcd_command_sequencer_unit
// Microcoded sequencer that expands display requests into controller byte
// writes for a two-half 128x64 page-addressed LCD.
// ----------------------------------------------------------------------------
`default_nettype none

module glcd_command_sequencer_unit #(
	parameter int GLYPH_COUNT  = 96,
	parameter int GLYPH_WIDTH  = 5,
	parameter int TEXT_COLUMNS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] func,
	input  wire logic [6:0] x_pos,
	input  wire logic [5:0] y_pos,
	input  wire logic [7:0] char_code,
	input  wire logic [6:0] glyph_index,
	input  wire logic [2:0] glyph_column,
	input  wire logic [7:0] glyph_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            half_select,
	output logic            reg_select,
	output logic [7:0]      bus_byte,
	output logic            last_write
);
	import gcs_pkg::*;

	localparam int DEPTH = GLYPH_COUNT * GLYPH_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] font_mem [DEPTH];

	logic          busy_q;
	pc_t           pc_q;
	logic [2:0]    cnt_q;
	logic [5:0]    x_q;
	logic          half_q;
	logic [2:0]    page_q;
	logic [7:0]    mask_q;
	logic [AW-1:0] base_q;
	logic [7:0]    rd_q;
	logic [3:0]    text_col_q;

	logic          out_valid_q;
	logic          half_q_out;
	logic          rs_q;
	logic [7:0]    byte_q;
	logic          last_q;

	uc_word_t      step;
	logic          stall;
	logic          adv;
	logic          take_loop;
	logic [3:0]    cnt_d;
	logic [7:0]    byte_d;
	logic          half_d;
	logic          last_d;
	logic          acc;
	logic          is_line;
	logic          is_print;
	logic          load_ok;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [4:0]    col_next;
	logic [7:0]    ch_off;

	assign in_ready    = !busy_q;
	assign acc         = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign half_select = half_q_out;
	assign reg_select  = rs_q;
	assign bus_byte    = byte_q;
	assign last_write  = last_q;

	assign step      = uc_rom(pc_q);
	assign stall     = step.emit && out_valid_q && !out_ready;
	assign adv       = busy_q && !stall;
	assign take_loop = step.loop && (cnt_q != 3'd7);
	assign last_d    = step.done && !take_loop;
	// counter value after this step, used to address the next font read
	assign cnt_d     = take_loop ? ({1'b0, cnt_q} + 4'd1) : 4'd0;
	assign rd_addr   = base_q + AW'(cnt_d);

	assign is_line  = (char_code >= LINE_FIRST) && (char_code <= LINE_LAST);
	assign is_print = (char_code >= CHAR_FIRST) &&
		({1'b0, char_code} < 9'(32 + GLYPH_COUNT));
	assign load_ok  = ({1'b0, glyph_index} < 8'(GLYPH_COUNT)) &&
		({1'b0, glyph_column} < 4'(GLYPH_WIDTH));
	assign wr_addr  = AW'(glyph_index) * AW'(GLYPH_WIDTH) + AW'(glyph_column);
	assign ch_off   = char_code - CHAR_FIRST;
	assign col_next = ({1'b0, text_col_q} + 5'd1 >= 5'(TEXT_COLUMNS)) ? 5'd0 :
		({1'b0, text_col_q} + 5'd1);

	always_comb begin
		case (step.hsel)
			H_LEFT:  half_d = 1'b0;
			H_RIGHT: half_d = 1'b1;
			H_REQ:   half_d = half_q;
			default: half_d = 1'b0;
		endcase
		case (step.bsel)
			B_CONST:    byte_d = step.cbyte;
			B_PAGE:     byte_d = CMD_PAGE | {5'd0, page_q};
			B_CNT_PAGE: byte_d = CMD_PAGE | {5'd0, cnt_q};
			B_YADDR:    byte_d = CMD_SET_Y | {2'd0, x_q};
			B_MASK:     byte_d = mask_q;
			B_FONT:     byte_d = ({1'b0, cnt_q} < 4'(GLYPH_WIDTH)) ? rd_q : 8'h00;
			default:    byte_d = 8'h00;
		endcase
	end

	// font store: written by load requests, read one step ahead of each glyph byte
	always_ff @(posedge clk) begin
		if (acc && func == FUNC_LOAD && load_ok) begin
			font_mem[wr_addr] <= glyph_byte;
		end
		if (adv && cnt_d < 4'(GLYPH_WIDTH)) begin
			rd_q <= font_mem[rd_addr];
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (acc) begin
			x_q    <= x_pos[5:0];
			half_q <= x_pos[6];
			page_q <= ~y_pos[5:3];
			mask_q <= 8'(10'd3 << (3'd7 - y_pos[2:0]));
			base_q <= AW'(ch_off) * AW'(GLYPH_WIDTH);
			if (func == FUNC_CHAR) begin
				if (is_line) begin
					page_q <= 3'(char_code - LINE_FIRST);
				end else begin
					half_q <= (5'(text_col_q) >= 5'(TEXT_COLUMNS / 2));
				end
			end
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= PC_INIT;
			cnt_q      <= 3'd0;
			text_col_q <= 4'd0;
		end else if (acc) begin
			cnt_q <= 3'd0;
			case (func)
				FUNC_INIT: begin
					busy_q <= 1'b1;
					pc_q   <= PC_INIT;
				end
				FUNC_CLEAR: begin
					busy_q <= 1'b1;
					pc_q   <= PC_CLEAR;
				end
				FUNC_PLOT: begin
					busy_q <= 1'b1;
					pc_q   <= PC_PLOT;
				end
				FUNC_CHAR: begin
					if (is_line) begin
						busy_q     <= 1'b1;
						pc_q       <= PC_LINE;
						text_col_q <= 4'd0;
					end else if (is_print) begin
						busy_q     <= 1'b1;
						pc_q       <= PC_CHAR;
						text_col_q <= col_next[3:0];
					end
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			if (take_loop) begin
				pc_q  <= step.tgt;
				cnt_q <= cnt_q + 3'd1;
			end else if (step.done) begin
				busy_q <= 1'b0;
				cnt_q  <= 3'd0;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && step.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && step.emit) begin
			half_q_out <= half_d;
			rs_q       <= step.rs;
			byte_q     <= byte_d;
			last_q     <= last_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/gcs_checker.sv -----
// ----------------------------------------------------------------------------
// gcs_checker
// Port-level checks on the GLCD command sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gcs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [2:0] func,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       reg_select,
	input wire logic [7:0] bus_byte
);
	import gcs_pkg::*;

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// init runs a program, so the input closes behind it
	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_INIT |=> !in_ready)
		else $error("input open during init program");

	// a font load makes no writes and leaves the input open
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_LOAD |=> in_ready)
		else $error("font load held the input");

	// the only command in the 0x00..0x3F range is display on
	a_cmd_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reg_select && bus_byte[7:6] == 2'b00 |-> bus_byte == CMD_DISP_ON)
		else $error("bad command byte");

endmodule

bind glcd_command_sequencer_unit gcs_checker u_gcs_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives display requests into the GLCD command sequencer with random valid
// and ready gaps, expands each accepted request into its expected byte writes
// and checks every write on the output field by field, in order.
// ----------------------------------------------------------------------------

module testbench;
	import gcs_pkg::*;

	localparam int GLYPHS    = 96;
	localparam int GLYPH_W   = 5;
	localparam int TEXT_COLS = 16;
	localparam int MAX_BURST = 24;

	// func codes the block leaves unused
	localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [6:0] x;
		logic [5:0] y;
		logic [7:0] ch;
		logic [6:0] gi;
		logic [2:0] gc;
		logic [7:0] gb;
	} request_t;

	typedef struct packed {
		logic       half;
		logic       rs;
		logic [7:0] data;
		logic       last;
	} write_t;

	typedef struct packed {
		request_t req;
		logic     lit;
		write_t   typed;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] func;
	logic [6:0] x_pos;
	logic [5:0] y_pos;
	logic [7:0] char_code;
	logic [6:0] glyph_index;
	logic [2:0] glyph_column;
	logic [7:0] glyph_byte;
	logic       out_valid;
	logic       out_ready;
	logic       half_select;
	logic       reg_select;
	logic [7:0] bus_byte;
	logic       last_write;

	// shadow of the block state
	logic [3:0] text_col;
	logic [7:0] font_mem [0:GLYPHS*GLYPH_W-1];
	bit         font_written [0:GLYPHS*GLYPH_W-1];
	bit         glyph_listed [0:GLYPHS-1];
	int         printable_glyphs [$];

	write_t     pending_writes [$];
	stim_row_t  directed_rows [$];
	int         mismatch_count;
	int         taken_items;
	int         send_gap_pct;
	int         recv_gap_pct;
	int         long_stall_left;
	bit         start_long_stall;

	glcd_command_sequencer_unit #(
		.GLYPH_COUNT (GLYPHS),
		.GLYPH_WIDTH (GLYPH_W),
		.TEXT_COLUMNS(TEXT_COLS)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.char_code   (char_code),
		.glyph_index (glyph_index),
		.glyph_column(glyph_column),
		.glyph_byte  (glyph_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.half_select (half_select),
		.reg_select  (reg_select),
		.bus_byte    (bus_byte),
		.last_write  (last_write)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic write_t mk_write(logic half, logic rs, logic [7:0] data);
		write_t w;
		w.half = half;
		w.rs   = rs;
		w.data = data;
		w.last = 1'b0;
		return w;
	endfunction

	function automatic stim_row_t make_row(logic [2:0] op, logic [6:0] x, logic [5:0] y,
			logic [7:0] ch, logic [6:0] gi, logic [2:0] gc, logic [7:0] gb,
			logic lit, logic half, logic rs, logic [7:0] data);
		stim_row_t s;
		s.req.op = op;
		s.req.x  = x;
		s.req.y  = y;
		s.req.ch = ch;
		s.req.gi = gi;
		s.req.gc = gc;
		s.req.gb = gb;
		s.lit    = lit;
		s.typed  = mk_write(half, rs, data);
		return s;
	endfunction

	function automatic request_t random_fields();
		request_t r;
		r.op = 3'($urandom_range(7));
		r.x  = 7'($urandom_range(127));
		r.y  = 6'($urandom_range(63));
		r.ch = 8'($urandom_range(255));
		r.gi = 7'($urandom_range(127));
		r.gc = 3'($urandom_range(7));
		r.gb = 8'($urandom_range(255));
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Expands one accepted request into its byte writes and updates the shadow
	// state. A typed row replaces the final write with its literal value.
	task automatic expand_request(input request_t r, input logic lit, input write_t typed,
			output bit effective);
		write_t     burst [0:MAX_BURST-1];
		write_t     w;
		logic [7:0] cmds [0:3];
		logic [2:0] page;
		logic [2:0] bitpos;
		logic       side;
		int         n;
		int         k;
		int         base;
		int         g;
		bit         full;
		n = 0;
		effective = 1'b1;
		cmds[0] = CMD_DISP_ON;
		cmds[1] = CMD_SET_Y;
		cmds[2] = CMD_PAGE;
		cmds[3] = CMD_START;
		case (r.op)
			FUNC_INIT: begin
				for (k = 0; k < 4; k++) begin
					burst[n]     = mk_write(1'b0, 1'b0, cmds[k]);
					burst[n + 1] = mk_write(1'b1, 1'b0, cmds[k]);
					n = n + 2;
				end
			end
			FUNC_CLEAR: begin
				for (k = 0; k < 8; k++) begin
					page = k[2:0];
					burst[n]     = mk_write(r.x[6], 1'b0, CMD_PAGE | {5'b0, page});
					burst[n + 1] = mk_write(r.x[6], 1'b0, CMD_SET_Y | {2'b0, r.x[5:0]});
					burst[n + 2] = mk_write(r.x[6], 1'b1, 8'h00);
					n = n + 3;
				end
			end
			FUNC_PLOT: begin
				// row 0 is the bottom: top page first, MSB is the lowest pixel
				page   = 3'd7 - r.y[5:3];
				bitpos = 3'd7 - r.y[2:0];
				burst[0] = mk_write(r.x[6], 1'b0, CMD_PAGE | {5'b0, page});
				burst[1] = mk_write(r.x[6], 1'b0, CMD_SET_Y | {2'b0, r.x[5:0]});
				burst[2] = mk_write(r.x[6], 1'b1, 8'h03 << bitpos);
				n = 3;
			end
			FUNC_CHAR: begin
				if (r.ch >= LINE_FIRST && r.ch <= LINE_LAST) begin
					page = r.ch[2:0] - 3'd1;
					burst[0] = mk_write(1'b0, 1'b0, CMD_PAGE | {5'b0, page});
					burst[1] = mk_write(1'b1, 1'b0, CMD_PAGE | {5'b0, page});
					burst[2] = mk_write(1'b0, 1'b0, CMD_SET_Y);
					burst[3] = mk_write(1'b1, 1'b0, CMD_SET_Y);
					n = 4;
					text_col = 4'd0;
				end else if (r.ch >= CHAR_FIRST && int'(r.ch) < int'(CHAR_FIRST) + GLYPHS) begin
					side = (int'(text_col) >= TEXT_COLS / 2);
					base = (int'(r.ch) - int'(CHAR_FIRST)) * GLYPH_W;
					for (k = 0; k < 8; k++)
						burst[k] = mk_write(side, 1'b1, (k < GLYPH_W) ? font_mem[base + k] : 8'h00);
					n = 8;
					if (int'(text_col) + 1 >= TEXT_COLS)
						text_col = 4'd0;
					else
						text_col = text_col + 4'd1;
				end else begin
					effective = 1'b0;
				end
			end
			FUNC_LOAD: begin
				if (r.gi < GLYPHS && r.gc < GLYPH_W) begin
					g = r.gi;
					font_mem[g * GLYPH_W + r.gc]     = r.gb;
					font_written[g * GLYPH_W + r.gc] = 1'b1;
					full = 1'b1;
					for (k = 0; k < GLYPH_W; k++)
						if (!font_written[g * GLYPH_W + k])
							full = 1'b0;
					if (full && !glyph_listed[g]) begin
						glyph_listed[g] = 1'b1;
						printable_glyphs.push_back(g);
					end
				end else begin
					effective = 1'b0;
				end
			end
			default: effective = 1'b0;
		endcase
		for (k = 0; k < n; k++) begin
			w = burst[k];
			if (k == n - 1) begin
				if (lit)
					w = typed;
				w.last = 1'b1;
			end
			pending_writes.push_back(w);
		end
	endtask

	task automatic send_request(input request_t r, input logic lit, input write_t typed);
		bit effective;
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		in_valid     <= 1'b1;
		func         <= r.op;
		x_pos        <= r.x;
		y_pos        <= r.y;
		char_code    <= r.ch;
		glyph_index  <= r.gi;
		glyph_column <= r.gc;
		glyph_byte   <= r.gb;
		do @(posedge clk); while (!in_ready);
		expand_request(r, lit, typed, effective);
		if (effective)
			taken_items++;
	endtask

	task automatic check_write();
		write_t want;
		if (pending_writes.size() == 0) begin
			report_mismatch($sformatf("unexpected write half=%0d rs=%0d byte=%02h",
				half_select, reg_select, bus_byte));
		end else begin
			want = pending_writes.pop_front();
			if (half_select !== want.half)
				report_mismatch($sformatf("half_select %0d, want %0d", half_select, want.half));
			if (reg_select !== want.rs)
				report_mismatch($sformatf("reg_select %0d, want %0d", reg_select, want.rs));
			if (bus_byte !== want.data)
				report_mismatch($sformatf("bus_byte %02h, want %02h", bus_byte, want.data));
			if (last_write !== want.last)
				report_mismatch($sformatf("last_write %0d, want %0d", last_write, want.last));
		end
	endtask

	// Random traffic until the count of requests that do something reaches goal.
	task automatic run_random(input int goal);
		request_t r;
		int       pick;
		int       len;
		int       g;
		int       k;
		int       start;
		while (taken_items < goal) begin
			pick = $urandom_range(99);
			r = random_fields();
			if (pick < 15) begin
				// whole glyph, columns in rotated order
				g = $urandom_range(GLYPHS - 1);
				start = $urandom_range(GLYPH_W - 1);
				for (k = 0; k < GLYPH_W; k++) begin
					r = random_fields();
					r.op = FUNC_LOAD;
					r.gi = 7'(g);
					r.gc = 3'((start + k) % GLYPH_W);
					send_request(r, 1'b0, '0);
				end
			end else if (pick < 45 && printable_glyphs.size() > 0) begin
				// a run of text, often from the start of a line
				if ($urandom_range(1)) begin
					r.op = FUNC_CHAR;
					r.ch = 8'($urandom_range(LINE_LAST, LINE_FIRST));
					send_request(r, 1'b0, '0);
				end
				len = $urandom_range(20, 1);
				repeat (len) begin
					r = random_fields();
					r.op = FUNC_CHAR;
					r.ch = CHAR_FIRST +
						8'(printable_glyphs[$urandom_range(printable_glyphs.size() - 1)]);
					send_request(r, 1'b0, '0);
				end
			end else begin
				if (pick < 52) begin
					r.op = FUNC_INIT;
				end else if (pick < 66) begin
					r.op = FUNC_PLOT;
				end else if (pick < 72) begin
					r.op = FUNC_CLEAR;
				end else if (pick < 78) begin
					r.op = FUNC_CHAR;
					r.ch = 8'($urandom_range(LINE_LAST, LINE_FIRST));
				end else if (pick < 88) begin
					// loads, some with index or column out of range
					r.op = FUNC_LOAD;
				end else if (pick < 95) begin
					r.op = FUNC_CHAR;
					case ($urandom_range(2))
						0: r.ch = 8'd0;
						1: r.ch = 8'($urandom_range(CHAR_FIRST - 1, LINE_LAST + 1));
						default: r.ch = 8'($urandom_range(255, int'(CHAR_FIRST) + GLYPHS));
					endcase
				end else begin
					r.op = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
				end
				send_request(r, 1'b0, '0);
			end
		end
	endtask

	// receiver: checks writes, stalls at random, and takes long hold-offs on request
	initial begin
		out_ready <= 1'b0;
		long_stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				check_write();
			if (long_stall_left > 0) begin
				long_stall_left--;
				out_ready <= 1'b0;
			end else if (start_long_stall) begin
				start_long_stall = 1'b0;
				long_stall_left = 400;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int i;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		func         <= '0;
		x_pos        <= '0;
		y_pos        <= '0;
		char_code    <= '0;
		glyph_index  <= '0;
		glyph_column <= '0;
		glyph_byte   <= '0;
		mismatch_count = 0;
		taken_items = 0;
		start_long_stall = 1'b0;
		text_col = 4'd0;
		for (i = 0; i < GLYPHS * GLYPH_W; i++) begin
			font_mem[i] = 8'h00;
			font_written[i] = 1'b0;
		end
		for (i = 0; i < GLYPHS; i++)
			glyph_listed[i] = 1'b0;

		//                            op           x     y     ch     gi     gc    gb
		directed_rows.push_back(make_row(FUNC_INIT,  7'd0, 6'd0, 8'd0, 7'd0, 3'd0, 8'd0,
			1'b1, 1'b1, 1'b0, CMD_START));
		directed_rows.push_back(make_row(FUNC_PLOT,  7'd0, 6'd0, 8'd0, 7'd0, 3'd0, 8'd0,
			1'b1, 1'b0, 1'b1, 8'h80));
		directed_rows.push_back(make_row(FUNC_PLOT,  7'd127, 6'd63, 8'hFF, 7'h7F, 3'd7, 8'hFF,
			1'b1, 1'b1, 1'b1, 8'h03));
		directed_rows.push_back(make_row(FUNC_PLOT,  7'd45, 6'd21, 8'd0, 7'd0, 3'd0, 8'd0,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_CLEAR, 7'd0, 6'd0, 8'd0, 7'd0, 3'd0, 8'd0,
			1'b1, 1'b0, 1'b1, 8'h00));
		directed_rows.push_back(make_row(FUNC_CLEAR, 7'd127, 6'd63, 8'hFF, 7'h7F, 3'd7, 8'hFF,
			1'b1, 1'b1, 1'b1, 8'h00));
		directed_rows.push_back(make_row(FUNC_CHAR,  7'd0, 6'd0, LINE_LAST, 7'd0, 3'd0, 8'd0,
			1'b1, 1'b1, 1'b0, CMD_SET_Y));
		directed_rows.push_back(make_row(FUNC_CHAR,  7'd0, 6'd0, LINE_FIRST, 7'd0, 3'd0, 8'd0,
			1'b1, 1'b1, 1'b0, CMD_SET_Y));
		// glyphs for the first and last printable codes
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd0, 3'd0, 8'h00,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd0, 3'd1, 8'hFF,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd0, 3'd2, 8'h5A,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd0, 3'd3, 8'hA5,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd0, 3'd4, 8'h81,
			1'b0, 1'b0, 1'b0, 8'h00));
		for (i = GLYPH_W - 1; i >= 0; i--)
			directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd95, i[2:0],
				8'h11 << i, 1'b0, 1'b0, 1'b0, 8'h00));
		// loads out of range go nowhere
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd96, 3'd0, 8'hC3,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd127, 6'd63, 8'hFF, 7'd127, 3'd7, 8'hFF,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_LOAD, 7'd0, 6'd0, 8'd0, 7'd0, 3'd5, 8'h77,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_CHAR, 7'd0, 6'd0, CHAR_FIRST, 7'd0, 3'd0, 8'd0,
			1'b1, 1'b0, 1'b1, 8'h00));
		directed_rows.push_back(make_row(FUNC_CHAR, 7'd0, 6'd0, 8'd127, 7'd0, 3'd0, 8'd0,
			1'b0, 1'b0, 1'b0, 8'h00));
		// codes that fall outside both ranges
		directed_rows.push_back(make_row(FUNC_CHAR, 7'd0, 6'd0, 8'd0, 7'd0, 3'd0, 8'd0,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_CHAR, 7'd0, 6'd0, 8'd255, 7'd0, 3'd0, 8'd0,
			1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_SPARE_HI, 7'd127, 6'd63, 8'hFF, 7'h7F, 3'd7,
			8'hFF, 1'b0, 1'b0, 1'b0, 8'h00));
		directed_rows.push_back(make_row(FUNC_SPARE_LO, 7'd0, 6'd0, 8'd0, 7'd0, 3'd0, 8'd0,
			1'b0, 1'b0, 1'b0, 8'h00));

		send_gap_pct = 25;
		recv_gap_pct = 69;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < directed_rows.size(); i++)
			send_request(directed_rows[i].req, directed_rows[i].lit, directed_rows[i].typed);

		run_random(120);
		send_gap_pct = 69;
		recv_gap_pct = 25;
		run_random(220);
		// no gaps; a long output hold-off backs the block up into its input
		send_gap_pct = 0;
		recv_gap_pct = 0;
		start_long_stall = 1'b1;
		run_random(320);

		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
